@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros used by the gradient span datapath
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define RGS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset
`define RGS_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

@@ rtl/rgs_pkg.sv @@
// ---------------------------------------------------------------------------
// rgs_pkg
// Shared types and constants of the rectangular gradient span generator.
// ---------------------------------------------------------------------------
`default_nettype none

package rgs_pkg;

  // Default sizes
  localparam int DEF_MAP_DEPTH = 1024;
  localparam int DEF_MAX_SPAN  = 64;

  // Stream payload layout (lowest bit first)
  localparam int IN_TDATA_W  = 88;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 32;
  localparam int IDX_LSB     = 0;
  localparam int IDX_W       = 10;
  localparam int COLOR_LSB   = 10;
  localparam int COLOR_W     = 32;
  localparam int SX_LSB      = 42;
  localparam int SY_LSB      = 58;
  localparam int COORD_W     = 16;
  localparam int LEN_LSB     = 74;
  localparam int LEN_W       = 7;

  // Item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_SPAN = 1'b1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_SPREAD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANTIALIAS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_LEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_XX  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_XY  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_YX  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_YY  = 3'd7;

  // Spread modes (the fourth code behaves as plain reflect)
  localparam logic [1:0] MODE_REFLECT  = 2'd0;
  localparam logic [1:0] MODE_REPEAT   = 2'd1;
  localparam logic [1:0] MODE_RESTRICT = 2'd2;
  localparam logic [1:0] MODE_PLAIN    = 2'd3;

  // Datapath widths
  localparam int PROD_W = 48;   // coefficient x coordinate
  localparam int UW     = 50;   // 16.16 coordinate and distance
  localparam int KW     = 32;   // whole-step table position
  localparam int BW     = 5;    // divider bit counter

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_SUM, S_ABS, S_DIST, S_DIV, S_IDX,
    S_RD0, S_CAP0, S_CAP1, S_SHADE, S_FADE, S_OUT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic in_ready;
    logic mul;
    logic sum;
    logic take_abs;
    logic dist_sub;
    logic div_step;
    logic idx;
    logic rd0;
    logic cap0;
    logic cap1;
    logic shade;
    logic fade;
    logic emit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic span_go;
    logic div_last;
    logic need_blend;
    logic last_pix;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

@@ rtl/rgs_ram.sv @@
// ---------------------------------------------------------------------------
// rgs_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module rgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/rgs_ctrl.sv @@
// ---------------------------------------------------------------------------
// rgs_ctrl
// Sequencer of the span generator: steps each pixel through distance,
// table-position division, table reads, shading and output.
// ---------------------------------------------------------------------------
`default_nettype none

module rgs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  rgs_pkg::status_t  status,
  output rgs_pkg::cmd_t     cmd
);
  import rgs_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (status.span_go) state_next = S_MUL;
      S_MUL:   state_next = S_SUM;
      S_SUM:   state_next = S_ABS;
      S_ABS:   state_next = S_DIST;
      S_DIST:  state_next = S_DIV;
      S_DIV:   if (status.div_last) state_next = S_IDX;
      S_IDX:   state_next = S_RD0;
      S_RD0:   state_next = S_CAP0;
      S_CAP0:  state_next = status.need_blend ? S_CAP1 : S_SHADE;
      S_CAP1:  state_next = S_SHADE;
      S_SHADE: state_next = S_FADE;
      S_FADE:  state_next = S_OUT;
      S_OUT: begin
        if (status.out_free) begin
          state_next = status.last_pix ? S_IDLE : S_ABS;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Command decode
  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE:  cmd.in_ready = 1'b1;
      S_MUL:   cmd.mul      = 1'b1;
      S_SUM:   cmd.sum      = 1'b1;
      S_ABS:   cmd.take_abs = 1'b1;
      S_DIST:  cmd.dist_sub = 1'b1;
      S_DIV:   cmd.div_step = 1'b1;
      S_IDX:   cmd.idx      = 1'b1;
      S_RD0:   cmd.rd0      = 1'b1;
      S_CAP0:  cmd.cap0     = 1'b1;
      S_CAP1:  cmd.cap1     = 1'b1;
      S_SHADE: cmd.shade    = 1'b1;
      S_FADE:  cmd.fade     = 1'b1;
      S_OUT:   cmd.emit     = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/rgs_datapath.sv @@
// ---------------------------------------------------------------------------
// rgs_datapath
// Configuration registers, color table, coordinate and distance pipeline,
// bit-serial table-position divider, shading and output register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rgs_datapath #(
  parameter int MAP_DEPTH = rgs_pkg::DEF_MAP_DEPTH,
  parameter int MAX_SPAN  = rgs_pkg::DEF_MAX_SPAN
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic [rgs_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  logic [rgs_pkg::IN_TUSER_W-1:0]    s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [rgs_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic                              m_tlast,
  input  logic                              cfg_valid,
  input  logic [rgs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rgs_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  rgs_pkg::cmd_t                     cmd,
  output rgs_pkg::status_t                  status
);
  import rgs_pkg::*;

  localparam int AW   = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int NW   = $clog2(MAP_DEPTH + 1);
  localparam int CNTW = $clog2(MAX_SPAN + 1);

  // Shading helpers
  function automatic logic [31:0] fade_alpha(input logic [31:0] c, input logic [8:0] a);
    logic [16:0] p;
    p = 17'(c[31:24]) * 17'(a);
    return {p[15:8], c[23:0]};
  endfunction

  function automatic logic [31:0] blend_last(input logic [31:0] c0, input logic [31:0] cl,
                                             input logic [8:0] a);
    logic [31:0] r;
    logic [16:0] acc;
    logic [8:0]  na;
    na = 9'd256 - a;
    r  = '0;
    for (int ch = 0; ch < 4; ch++) begin
      acc = 17'(na) * 17'(c0[ch*8 +: 8]) + 17'(a) * 17'(cl[ch*8 +: 8]);
      r[ch*8 +: 8] = acc[15:8];
    end
    return r;
  endfunction

  // Configuration registers
  logic [1:0]         spread_mode;
  logic               antialias;
  logic [10:0]        map_length;
  logic [14:0]        inner_offset;
  logic signed [31:0] coef_xx, coef_xy, coef_yx, coef_yy;

  always_ff @(posedge clk) begin
    if (rst) begin
      spread_mode  <= MODE_REFLECT;
      antialias    <= 1'b0;
      map_length   <= 11'd32;
      inner_offset <= '0;
      coef_xx      <= 32'sd65536;
      coef_xy      <= '0;
      coef_yx      <= '0;
      coef_yy      <= 32'sd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SPREAD:    spread_mode  <= cfg_data[1:0];
        CFG_ANTIALIAS: antialias    <= cfg_data[0];
        CFG_MAP_LEN:   map_length   <= cfg_data[10:0];
        CFG_INNER:     inner_offset <= cfg_data[14:0];
        CFG_COEF_XX:   coef_xx      <= $signed(cfg_data);
        CFG_COEF_XY:   coef_xy      <= $signed(cfg_data);
        CFG_COEF_YX:   coef_yx      <= $signed(cfg_data);
        CFG_COEF_YY:   coef_yy      <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Effective mode, antialias and table length
  logic [1:0]    mode_eff;
  logic          aa_eff;
  logic [31:0]   ml_w, n32;
  logic [NW-1:0] n_val;

  always_comb begin
    mode_eff = (spread_mode == MODE_PLAIN) ? MODE_REFLECT : spread_mode;
    aa_eff   = antialias && (spread_mode != MODE_PLAIN);
    ml_w     = 32'(map_length);
    if (ml_w == 32'd0)                n32 = 32'd1;
    else if (ml_w > 32'(MAP_DEPTH))   n32 = 32'(MAP_DEPTH);
    else                              n32 = ml_w;
    n_val    = n32[NW-1:0];
  end

  // Input unpacking
  logic                     in_kind;
  logic [IDX_W-1:0]         in_index;
  logic [COLOR_W-1:0]       in_color;
  logic signed [COORD_W-1:0] in_sx, in_sy;
  logic [LEN_W-1:0]         in_len;
  logic [CNTW-1:0]          len_cut;
  logic                     accept;
  logic [31:0]              ld_wide;
  logic                     ld_en;

  assign in_kind  = s_tuser[0];
  assign in_index = s_tdata[IDX_LSB +: IDX_W];
  assign in_color = s_tdata[COLOR_LSB +: COLOR_W];
  assign in_sx    = $signed(s_tdata[SX_LSB +: COORD_W]);
  assign in_sy    = $signed(s_tdata[SY_LSB +: COORD_W]);
  assign in_len   = s_tdata[LEN_LSB +: LEN_W];
  assign len_cut  = (in_len > LEN_W'(MAX_SPAN)) ? CNTW'(MAX_SPAN) : CNTW'(in_len);
  assign accept   = s_tvalid && cmd.in_ready;
  assign ld_wide  = 32'(in_index);
  assign ld_en    = accept && (in_kind == KIND_LOAD) && (ld_wide < 32'(MAP_DEPTH));
  assign status.span_go = accept && (in_kind == KIND_SPAN) && (len_cut != '0);

  // Span registers and coordinate pipeline
  logic signed [COORD_W-1:0] x0, y0;
  logic [CNTW-1:0]           remaining;
  logic signed [PROD_W-1:0]  p_xx, p_xy, p_yx, p_yy;
  logic signed [UW-1:0]      u, v, ll;
  logic [UW-1:0]             au, av, dmax, adj;

  assign dmax = (au > av) ? au : av;
  assign adj  = UW'({inner_offset, 16'h0000}) - (aa_eff ? UW'(0) : UW'(32768));

  always_ff @(posedge clk) begin
    if (status.span_go) begin
      x0 <= in_sx;
      y0 <= in_sy;
    end
    if (cmd.mul) begin
      p_xx <= PROD_W'(coef_xx) * PROD_W'(x0);
      p_xy <= PROD_W'(coef_xy) * PROD_W'(y0);
      p_yx <= PROD_W'(coef_yx) * PROD_W'(x0);
      p_yy <= PROD_W'(coef_yy) * PROD_W'(y0);
    end
    if (cmd.sum) begin
      u <= UW'(p_xx) + UW'(p_xy);
      v <= UW'(p_yx) + UW'(p_yy);
    end else if (cmd.emit) begin
      u <= u + UW'(coef_xx);
      v <= v + UW'(coef_yx);
    end
    if (cmd.take_abs) begin
      au <= u[UW-1] ? UW'(-u) : UW'(u);
      av <= v[UW-1] ? UW'(-v) : UW'(v);
    end
    if (cmd.dist_sub) begin
      ll <= $signed(dmax) - $signed(adj);
    end
  end

  // Pixel counter
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (status.span_go) begin
      remaining <= len_cut;
    end else if (cmd.emit) begin
      remaining <= remaining - CNTW'(1);
    end
  end
  assign status.last_pix = (remaining == CNTW'(1));

  // Bit-serial remainder of the table position by twice the table length
  logic [KW-1:0]   kval;
  logic [BW-1:0]   bitcnt;
  logic [NW:0]     rem;
  logic [NW+1:0]   rem_sh, n2e, rem_sub;

  assign kval    = ll[16 +: KW];
  assign n2e     = {1'b0, n_val, 1'b0};
  assign rem_sh  = {rem, kval[bitcnt]};
  assign rem_sub = rem_sh - n2e;
  assign status.div_last = (bitcnt == '0);

  always_ff @(posedge clk) begin
    if (cmd.dist_sub) begin
      rem    <= '0;
      bitcnt <= BW'(KW - 1);
    end else if (cmd.div_step) begin
      rem    <= (rem_sh >= n2e) ? rem_sub[NW:0] : rem_sh[NW:0];
      bitcnt <= bitcnt - BW'(1);
    end
  end

  // Table index and shading flags
  logic          odd;
  logic [NW:0]   r_full;
  logic [NW-1:0] r_n, idx_ref, addr_w;
  logic          kneg, k_lt_n, k_is0, k_last;
  logic          zero_w, fout_w, fin_w, blend_w;

  always_comb begin
    odd     = rem >= {1'b0, n_val};
    r_full  = odd ? (rem - {1'b0, n_val}) : rem;
    r_n     = r_full[NW-1:0];
    idx_ref = odd ? (n_val - NW'(1) - r_n) : r_n;
    kneg    = ll[UW-1];
    k_lt_n  = kval < 32'(n_val);
    k_is0   = (kval == '0);
    k_last  = (kval == (32'(n_val) - 32'd1));
    zero_w  = 1'b0;
    fout_w  = 1'b0;
    fin_w   = 1'b0;
    blend_w = 1'b0;
    addr_w  = r_n;
    if (kneg) begin
      zero_w = 1'b1;
    end else begin
      case (mode_eff)
        MODE_RESTRICT: begin
          if (!k_lt_n) begin
            zero_w = 1'b1;
          end else begin
            addr_w = kval[NW-1:0];
            fout_w = aa_eff && k_last;
            fin_w  = aa_eff && k_is0 && (inner_offset != '0);
          end
        end
        MODE_REPEAT: begin
          addr_w = r_n;
          if (aa_eff) begin
            fin_w   = k_is0;
            blend_w = !k_is0 && (r_n == '0);
          end
        end
        default: begin
          addr_w = idx_ref;
          fin_w  = aa_eff && k_is0;
        end
      endcase
    end
  end

  logic [AW-1:0] idx_r;
  logic          zero_r, fout_r, fin_r, blend_r;
  logic [7:0]    frac8;

  always_ff @(posedge clk) begin
    if (cmd.idx) begin
      idx_r   <= AW'(addr_w);
      zero_r  <= zero_w;
      fout_r  <= fout_w;
      fin_r   <= fin_w;
      blend_r <= blend_w;
      frac8   <= ll[15:8];
    end
  end
  assign status.need_blend = blend_r;

  // Color table
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_data;

  assign rd_en   = cmd.rd0 || (cmd.cap0 && blend_r);
  assign rd_addr = cmd.rd0 ? idx_r : AW'(n_val - NW'(1));

  rgs_ram #(
    .WIDTH (32),
    .DEPTH (MAP_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ld_en),
    .wr_addr (AW'(ld_wide)),
    .wr_data (in_color),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Shading
  logic [31:0] c0, cl, pix;
  logic [8:0]  ain, aout;

  assign ain  = 9'd1 + 9'(frac8);
  assign aout = 9'd256 - 9'(frac8);

  always_ff @(posedge clk) begin
    if (cmd.cap0) c0 <= rd_data;
    if (cmd.cap1) cl <= rd_data;
    if (cmd.shade) begin
      if (zero_r)       pix <= '0;
      else if (blend_r) pix <= blend_last(c0, cl, aout);
      else if (fout_r)  pix <= fade_alpha(c0, aout);
      else              pix <= c0;
    end else if (cmd.fade && fin_r && !zero_r) begin
      pix <= fade_alpha(pix, ain);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= pix;
      m_tlast <= status.last_pix;
    end
  end
  assign status.out_free = !m_tvalid || m_tready;

  // Checks
  `RGS_ASSERT(a_rem_bound, clk, rst, cmd.div_step |=> ({1'b0, rem} < n2e), "remainder exceeds twice table length")
  `RGS_ASSERT(a_rd_addr, clk, rst, rd_en |-> (32'(rd_addr) < 32'(n_val)), "table read beyond length in use")
  `RGS_NEVER(a_emit_busy, clk, rst, cmd.emit && !status.out_free, "pixel overwrote an untaken result")

endmodule

`default_nettype wire

@@ rtl/rectangular_gradient_span.sv @@
// Load transaction: written to the color table at acceptance.
// Span transaction: multiply and sum setup, then per pixel absolute value,
// distance, the bit-serial remainder divider, index, table read, capture (a
// second capture on a repeat wrap blend), shade, fade and output (held while
// the output register is full). A new item is taken once the last pixel is in the output register.
// Reset (rst, synchronous) restores register defaults; the table is not cleared.
// ---------------------------------------------------------------------------
// rectangular_gradient_span
// Rectangular gradient span fill with reflect, repeat and restrict spread.
// ---------------------------------------------------------------------------
`default_nettype none

module rectangular_gradient_span #(
  parameter int MAP_DEPTH = rgs_pkg::DEF_MAP_DEPTH,
  parameter int MAX_SPAN  = rgs_pkg::DEF_MAX_SPAN
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // map_index, map_color, start_x, start_y, span_length, zero pad
  input  logic [rgs_pkg::IN_TDATA_W-1:0]  s_tdata,
  // kind
  input  logic [rgs_pkg::IN_TUSER_W-1:0]  s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // pixel_color
  output logic [rgs_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                            m_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rgs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rgs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rgs_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign s_tready  = cmd.in_ready;
  assign cfg_ready = 1'b1;

  // Sequencer
  rgs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  // Datapath
  rgs_datapath #(
    .MAP_DEPTH (MAP_DEPTH),
    .MAX_SPAN  (MAX_SPAN)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire

@@ tb/tb_rectangular_gradient_span.sv @@
// ---------------------------------------------------------------------------
// tb_rectangular_gradient_span
// Self-checking bench for the rectangular gradient span generator. Color
// table loads and spans are streamed in under several register settings; a
// scoreboard recomputes each pixel and compares it with every output
// transaction.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_rectangular_gradient_span;
  import rgs_pkg::*;

  typedef struct {
    logic [31:0] color;
    logic        last;
  } pixel_t;

  // Pixel predictor and store of pixels still owed by the block
  class pixel_scoreboard;
    bit [31:0]   color_map [DEF_MAP_DEPTH];
    bit [1:0]    spread;
    bit          aa;
    bit [10:0]   map_len;
    bit [14:0]   inner;
    longint      cxx, cxy, cyx, cyy;
    pixel_t      owed_pixels[$];
    int          errors;

    function new();
      spread  = MODE_REFLECT;
      aa      = 1'b0;
      map_len = 11'd32;
      inner   = '0;
      cxx     = 65536;
      cxy     = 0;
      cyx     = 0;
      cyy     = 65536;
      errors  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
      case (idx)
        CFG_SPREAD:    spread  = v[1:0];
        CFG_ANTIALIAS: aa      = v[0];
        CFG_MAP_LEN:   map_len = v[10:0];
        CFG_INNER:     inner   = v[14:0];
        CFG_COEF_XX:   cxx     = longint'(signed'(v));
        CFG_COEF_XY:   cxy     = longint'(signed'(v));
        CFG_COEF_YX:   cyx     = longint'(signed'(v));
        CFG_COEF_YY:   cyy     = longint'(signed'(v));
        default: ;
      endcase
    endfunction

    function bit [31:0] fade(bit [31:0] c, int unsigned a);
      int unsigned al;
      al = (c[31:24] * a) >> 8;
      return {al[7:0], c[23:0]};
    endfunction

    function bit [31:0] blend_to_last(bit [31:0] c0, bit [31:0] cl, int unsigned a);
      bit [31:0]   r;
      int unsigned ch;
      for (int sh = 0; sh < 32; sh += 8) begin
        ch = ((256 - a) * ((c0 >> sh) & 8'hFF) + a * ((cl >> sh) & 8'hFF)) >> 8;
        r[sh +: 8] = ch[7:0];
      end
      return r;
    endfunction

    function longint mirror(longint k, longint n);
      return ((k % (2 * n)) >= n) ? n - 1 - (k % n) : k % n;
    endfunction

    // Color of one pixel at signed 16.16 distance past the inner edge
    function bit [31:0] shade(longint ll, longint n);
      bit [1:0]    mode;
      bit          soft_edge;
      longint      k;
      longint      r;
      int unsigned f8;
      bit [31:0]   c;
      mode = spread;
      soft_edge = aa && (mode != MODE_PLAIN);
      if (mode == MODE_PLAIN) mode = MODE_REFLECT;
      if (!soft_edge) begin
        k = (ll + 32768) >>> 16;
        if (k < 0) return 0;
        if (mode == MODE_REFLECT) return color_map[mirror(k, n)];
        if (mode == MODE_REPEAT) return color_map[k % n];
        return (k < n) ? color_map[k] : 32'd0;
      end
      k  = ll >>> 16;
      if (k < 0) return 0;
      f8 = 32'((ll & 64'hFFFF) >> 8);
      if (mode == MODE_RESTRICT) begin
        if (k >= n) return 0;
        c = color_map[k];
        if (k == n - 1) c = fade(c, 256 - f8);
        if (k == 0 && inner != 0) c = fade(c, 1 + f8);
        return c;
      end
      if (k == 0) return fade(color_map[0], 1 + f8);
      if (mode == MODE_REFLECT) return color_map[mirror(k, n)];
      r = k % n;
      c = color_map[r];
      if (r == 0) c = blend_to_last(c, color_map[n - 1], 256 - f8);
      return c;
    endfunction

    // Accepted input transaction: load an entry or queue a span's pixels
    function void note_item(logic kind, logic [9:0] idx, logic [31:0] color,
                            logic [15:0] sx, logic [15:0] sy, logic [6:0] len);
      longint n, cnt, x, y, u, v, d;
      pixel_t p;
      if (kind == KIND_LOAD) begin
        color_map[idx] = color;
        return;
      end
      n   = (map_len == 0) ? 1 : (map_len > DEF_MAP_DEPTH) ? DEF_MAP_DEPTH : map_len;
      cnt = (len > DEF_MAX_SPAN) ? DEF_MAX_SPAN : len;
      y   = longint'(signed'(sy));
      for (longint i = 0; i < cnt; i++) begin
        x = longint'(signed'(sx)) + i;
        u = cxx * x + cxy * y;
        v = cyx * x + cyy * y;
        if (u < 0) u = -u;
        if (v < 0) v = -v;
        d = (u > v) ? u : v;
        p.color = shade(d - longint'(inner) * 65536, n);
        p.last  = (i + 1 == cnt);
        owed_pixels.push_back(p);
      end
    endfunction

    function void check_pixel(logic [31:0] color, logic last);
      pixel_t e;
      if (owed_pixels.size() == 0) begin
        $display("%0t: unexpected pixel expected none actual %h last %0d",
                 $time, color, last);
        errors++;
        return;
      end
      e = owed_pixels.pop_front();
      if (color !== e.color) begin
        $display("%0t: pixel_color mismatch expected %h actual %h", $time, e.color, color);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last mismatch expected %0d actual %0d", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic [IN_TUSER_W-1:0]  s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  pixel_scoreboard sb = new();
  bit              calm;      // no idling on either side
  int              filled;    // entries 0..filled-1 have been loaded

  rectangular_gradient_span DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100000000;
    $display("FAILURE");
    $finish;
  end

  // Output side: random stall bursts, checked on every accepted transaction
  initial begin
    m_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_pixel(m_tdata, m_tlast);
  end

  // One input transaction, with an optional idle burst ahead of it
  task automatic send_item(logic kind, logic [9:0] idx, logic [31:0] color,
                           logic [15:0] sx, logic [15:0] sy, logic [6:0] len);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[IDX_LSB +: IDX_W]     = idx;
    d[COLOR_LSB +: COLOR_W] = color;
    d[SX_LSB +: COORD_W]    = sx;
    d[SY_LSB +: COORD_W]    = sy;
    d[LEN_LSB +: LEN_W]     = len;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= kind;
    do @(posedge clk); while (!s_tready);
    sb.note_item(kind, idx, color, sx, sy, len);
  endtask

  task automatic load(logic [9:0] idx);
    send_item(KIND_LOAD, idx, $urandom, 16'($urandom), 16'($urandom), 7'($urandom));
  endtask

  task automatic span(logic [15:0] sx, logic [15:0] sy, logic [6:0] len);
    send_item(KIND_SPAN, 10'($urandom), $urandom, sx, sy, len);
  endtask

  // Load every table entry the next spans can reach
  task automatic fill_map(int len_reg);
    int n;
    n = (len_reg == 0) ? 1 : (len_reg > DEF_MAP_DEPTH) ? DEF_MAP_DEPTH : len_reg;
    while (filled < n) begin
      load(10'(filled));
      filled++;
    end
  endtask

  // Let the block run dry before touching registers
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.owed_pixels.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, v);
  endtask

  function automatic logic [31:0] pick_coef();
    logic [31:0] extremes [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
    case ($urandom_range(0, 5))
      0: return extremes[$urandom_range(0, 3)];
      1: return $urandom;
      default: return $urandom_range(0, 1 << 18) - (1 << 17);
    endcase
  endfunction

  function automatic logic [15:0] pick_coord();
    if ($urandom_range(0, 4) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 400) - 200);
  endfunction

  function automatic logic [6:0] pick_len();
    case ($urandom_range(0, 19))
      0: return 7'd0;
      1: return 7'($urandom_range(65, 127));
      2, 3: return 7'($urandom_range(17, 64));
      default: return 7'($urandom_range(1, 16));
    endcase
  endfunction

  initial begin
    int map_len;
    int lens [6] = '{0, 1, 2, 64, 1024, 2047};
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    calm      = 1'b0;
    filled    = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings, field extremes, empty and oversized spans
    fill_map(32);
    span(16'd0, 16'd0, 7'd1);
    span(16'h8000, 16'h8000, 7'd64);
    span(16'h7FFF, 16'h7FFF, 7'd127);
    span(16'd0, 16'd0, 7'd0);
    span(16'hFFF0, 16'd3, 7'd40);
    send_item(KIND_LOAD, 10'h3FF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 7'h7F);
    send_item(KIND_SPAN, 10'h3FF, 32'hFFFF_FFFF, 16'd5, 16'hFFFB, 7'd20);
    drain();

    // Phases: every spread mode with and without antialias, then random
    for (int ph = 0; ph < 14; ph++) begin
      if (ph == 12) calm = 1'b1;
      if (ph < 8) map_len = $urandom_range(2, 40);
      else if ($urandom_range(0, 1) == 0) map_len = lens[$urandom_range(0, 5)];
      else map_len = $urandom_range(1, 64);
      write_reg(CFG_SPREAD, (ph < 8) ? ph % 4 : $urandom_range(0, 3));
      write_reg(CFG_ANTIALIAS, (ph < 8) ? ph / 4 : $urandom_range(0, 1));
      write_reg(CFG_MAP_LEN, map_len);
      write_reg(CFG_INNER, (ph == 9) ? 32'd32767 : ($urandom_range(0, 1) ?
                0 : $urandom_range(1, 20)));
      write_reg(CFG_COEF_XX, pick_coef());
      write_reg(CFG_COEF_XY, pick_coef());
      write_reg(CFG_COEF_YX, pick_coef());
      write_reg(CFG_COEF_YY, pick_coef());
      cfg_valid <= 1'b0;
      fill_map(map_len);
      for (int i = 0; i < 26; i++) begin
        if ($urandom_range(0, 5) == 0) load(10'($urandom_range(0, 1023)));
        else span(pick_coord(), pick_coord(), pick_len());
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (sb.owed_pixels.size() != 0)
      $display("%0t: %0d pixels expected but never produced", $time,
               sb.owed_pixels.size());
    if (sb.errors == 0 && sb.owed_pixels.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
